// ===== hw/rtl/bytecode_instruction_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef BYTECODE_INSTRUCTION_DEFRAMER_MACROS_SVH
`define BYTECODE_INSTRUCTION_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define BIDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define BIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BIDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bidf_pkg.sv =====
// Package with result codes, operand kinds and the opcode table of the deframer.
package bidf_pkg;

    localparam int unsigned NUM_OPCODES = 63;

    // Result kinds.
    localparam logic [1:0] KIND_INSTR  = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_HEADER = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Operand kinds.
    localparam logic [2:0] OPND_NONE   = 3'd0;
    localparam logic [2:0] OPND_LABEL  = 3'd1;
    localparam logic [2:0] OPND_CADDR  = 3'd2;
    localparam logic [2:0] OPND_CHAR   = 3'd3;
    localparam logic [2:0] OPND_INT    = 3'd4;
    localparam logic [2:0] OPND_DOUBLE = 3'd5;
    localparam logic [2:0] OPND_MSG    = 3'd6;

    // Operand kind of each opcode; codes past the last opcode have none.
    function automatic logic [2:0] op_kind(input logic [5:0] opc);
        logic [2:0] k;
        k = OPND_NONE;
        if (opc >= 6'd17 && opc <= 6'd19) begin
            k = OPND_CADDR;
        end else if (opc >= 6'd20 && opc <= 6'd33) begin
            k = OPND_LABEL;
        end else if (opc == 6'd34 || opc == 6'd49) begin
            k = OPND_CHAR;
        end else if (opc == 6'd35 || opc == 6'd50) begin
            k = OPND_INT;
        end else if (opc == 6'd36 || opc == 6'd51) begin
            k = OPND_DOUBLE;
        end else if (opc == 6'd37 || (opc >= 6'd41 && opc <= 6'd48)
                     || (opc >= 6'd53 && opc <= 6'd60)) begin
            k = OPND_LABEL;
        end else if (opc == 6'd38 || opc == 6'd52) begin
            k = OPND_MSG;
        end
        return k;
    endfunction

    // Number of operand bytes that follow the opcode for each operand kind.
    function automatic logic [3:0] opnd_bytes(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            OPND_LABEL:  n = 4'd2;
            OPND_CADDR:  n = 4'd2;
            OPND_CHAR:   n = 4'd1;
            OPND_INT:    n = 4'd4;
            OPND_DOUBLE: n = 4'd8;
            OPND_MSG:    n = 4'd1;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/bytecode_instruction_deframer.sv =====
// Top level of the bytecode instruction deframer.
//
// The input channel takes one byte of an object file per beat (i_valid,
// i_in_byte, o_stall). The first HEADER_SKIP bytes are dropped, the next four
// give one header beat with the data and code segment sizes, and every byte
// after that is an opcode or operand byte. The output channel (o_valid,
// i_stall and the result fields) carries at most one beat per input byte:
// the header, an instruction on its last byte, each message character, or
// an error beat for an opcode of 63 or more; then all input is swallowed.
//
// A byte is held in an input register, decoded against the parse state and
// written to the output register, which drives the outputs. One byte is
// taken every cycle while the receiver does not stall; the only loop is the
// parse state update, computed from the held byte and the current state.
// When the receiver stalls with a result waiting, the input register keeps
// one more byte and then o_stall rises.
// A synchronous reset (i_rst_n low) returns the parser to the header and
// clears both registers' valid flags.

`include "bytecode_instruction_deframer_macros.svh"

module bytecode_instruction_deframer #(
    parameter int unsigned HEADER_SKIP = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_in_byte,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_address,
    output logic [5:0]  o_opcode,
    output logic [2:0]  o_operand_kind,
    output logic [63:0] o_operand_value,
    output logic [7:0]  o_message_char,
    output logic        o_last_char,
    output logic [15:0] o_data_segment_size,
    output logic [15:0] o_code_segment_size,
    output logic [7:0]  o_bad_opcode
);

    localparam int unsigned HCW = $clog2(HEADER_SKIP + 4);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OPCODE,
        PH_OPERAND,
        PH_MESSAGE
    } t_phase;

    // Input register.
    logic           r_in_valid;
    logic [7:0]     r_in_byte;

    // Parse state.
    t_phase         r_phase,     n_phase;
    logic [HCW-1:0] r_hdr_cnt,   n_hdr_cnt;
    logic [3:0]     r_left,      n_left;
    logic [63:0]    r_opnd,      n_opnd;
    logic [5:0]     r_opcode,    n_opcode;
    logic [15:0]    r_instr_adr, n_instr_adr;
    logic [15:0]    r_run_adr,   n_run_adr;
    logic [7:0]     r_msg_left,  n_msg_left;
    logic           r_halted,    n_halted;

    // Output register.
    logic           r_out_valid;
    logic [1:0]     r_kind,   n_kind;
    logic [15:0]    r_addr,   n_addr;
    logic [5:0]     r_opc,    n_opc;
    logic [2:0]     r_okind,  n_okind;
    logic [63:0]    r_val,    n_val;
    logic [7:0]     r_char,   n_char;
    logic           r_last,   n_last;
    logic [15:0]    r_dsz,    n_dsz;
    logic [15:0]    r_csz,    n_csz;
    logic [7:0]     r_bad,    n_bad;
    logic           n_emit;

    logic           adv;
    logic           step;

    // Temporaries of the decode.
    logic [1:0]     hdr_idx;
    logic [31:0]    hdr_word;
    logic [2:0]     cur_kind;
    logic [3:0]     cur_total;
    logic [2:0]     opnd_idx;
    logic [63:0]    opnd_word;
    logic [2:0]     new_kind;
    logic [3:0]     new_bytes;

    // The output register can be loaded when it is empty or being taken.
    assign adv     = !r_out_valid || !i_stall;
    assign step    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_left      = r_left;
        n_opnd      = r_opnd;
        n_opcode    = r_opcode;
        n_instr_adr = r_instr_adr;
        n_run_adr   = r_run_adr;
        n_msg_left  = r_msg_left;
        n_halted    = r_halted;

        n_emit  = 1'b0;
        n_kind  = bidf_pkg::KIND_INSTR;
        n_addr  = '0;
        n_opc   = '0;
        n_okind = bidf_pkg::OPND_NONE;
        n_val   = '0;
        n_char  = '0;
        n_last  = 1'b0;
        n_dsz   = '0;
        n_csz   = '0;
        n_bad   = '0;

        hdr_idx   = 2'(r_hdr_cnt - HCW'(HEADER_SKIP));
        hdr_word  = r_opnd[31:0] | (32'(r_in_byte) << {hdr_idx, 3'b000});
        cur_kind  = bidf_pkg::op_kind(r_opcode);
        cur_total = bidf_pkg::opnd_bytes(cur_kind);
        opnd_idx  = 3'(cur_total - r_left);
        opnd_word = r_opnd | (64'(r_in_byte) << {opnd_idx, 3'b000});
        new_kind  = bidf_pkg::op_kind(r_in_byte[5:0]);
        new_bytes = bidf_pkg::opnd_bytes(new_kind);

        if (step && !r_halted) begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + HCW'(1);
                    if (r_hdr_cnt >= HCW'(HEADER_SKIP)) begin
                        if (hdr_idx == 2'd3) begin
                            n_emit  = 1'b1;
                            n_kind  = bidf_pkg::KIND_HEADER;
                            n_dsz   = hdr_word[15:0];
                            n_csz   = hdr_word[31:16];
                            n_opnd  = '0;
                            n_phase = PH_OPCODE;
                        end else begin
                            n_opnd = 64'(hdr_word);
                        end
                    end
                end
                PH_OPCODE: begin
                    if (r_in_byte >= 8'(bidf_pkg::NUM_OPCODES)) begin
                        n_emit   = 1'b1;
                        n_kind   = bidf_pkg::KIND_ERROR;
                        n_addr   = r_run_adr;
                        n_bad    = r_in_byte;
                        n_halted = 1'b1;
                    end else begin
                        n_opcode    = r_in_byte[5:0];
                        n_instr_adr = r_run_adr;
                        n_run_adr   = r_run_adr + 16'd1 + 16'(new_bytes);
                        n_opnd      = '0;
                        if (new_bytes == 4'd0) begin
                            n_emit  = 1'b1;
                            n_addr  = r_run_adr;
                            n_opc   = r_in_byte[5:0];
                            n_okind = new_kind;
                        end else begin
                            n_left  = new_bytes;
                            n_phase = PH_OPERAND;
                        end
                    end
                end
                PH_OPERAND: begin
                    n_opnd = opnd_word;
                    n_left = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
                    if (r_left <= 4'd1) begin
                        n_emit  = 1'b1;
                        n_addr  = r_instr_adr;
                        n_opc   = r_opcode;
                        n_okind = cur_kind;
                        n_val   = opnd_word;
                        if (cur_kind == bidf_pkg::OPND_MSG) begin
                            n_run_adr  = r_run_adr + 16'(r_in_byte);
                            n_msg_left = r_in_byte;
                            n_phase    = (r_in_byte != 8'd0) ? PH_MESSAGE : PH_OPCODE;
                        end else begin
                            n_phase = PH_OPCODE;
                        end
                    end
                end
                PH_MESSAGE: begin
                    n_emit     = 1'b1;
                    n_kind     = bidf_pkg::KIND_CHAR;
                    n_addr     = r_instr_adr;
                    n_opc      = r_opcode;
                    n_okind    = bidf_pkg::OPND_MSG;
                    n_char     = r_in_byte;
                    n_msg_left = (r_msg_left != 8'd0) ? r_msg_left - 8'd1 : 8'd0;
                    if (r_msg_left <= 8'd1) begin
                        n_last  = 1'b1;
                        n_phase = PH_OPCODE;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_left      <= '0;
            r_opnd      <= '0;
            r_opcode    <= '0;
            r_instr_adr <= '0;
            r_run_adr   <= '0;
            r_msg_left  <= '0;
            r_halted    <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in_byte;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_left      <= n_left;
            r_opnd      <= n_opnd;
            r_opcode    <= n_opcode;
            r_instr_adr <= n_instr_adr;
            r_run_adr   <= n_run_adr;
            r_msg_left  <= n_msg_left;
            r_halted    <= n_halted;

            if (adv) begin
                r_out_valid <= n_emit;
                r_kind      <= n_kind;
                r_addr      <= n_addr;
                r_opc       <= n_opc;
                r_okind     <= n_okind;
                r_val       <= n_val;
                r_char      <= n_char;
                r_last      <= n_last;
                r_dsz       <= n_dsz;
                r_csz       <= n_csz;
                r_bad       <= n_bad;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_kind              = r_kind;
    assign o_address           = r_addr;
    assign o_opcode            = r_opc;
    assign o_operand_kind      = r_okind;
    assign o_operand_value     = r_val;
    assign o_message_char      = r_char;
    assign o_last_char         = r_last;
    assign o_data_segment_size = r_dsz;
    assign o_code_segment_size = r_csz;
    assign o_bad_opcode        = r_bad;

    `BIDF_ASSERT_NEXT(a_halt_silent, i_clk, i_rst_n, r_halted && adv, !o_valid, "beat after halt")
    `BIDF_ASSERT_NOW(a_halt_reports, i_clk, i_rst_n, $rose(r_halted), o_valid && o_kind == bidf_pkg::KIND_ERROR, "halt without error beat")
    `BIDF_ASSERT_NOW(a_char_kind, i_clk, i_rst_n, o_valid && o_kind == bidf_pkg::KIND_CHAR, o_operand_kind == bidf_pkg::OPND_MSG, "character beat outside message")

endmodule
